/* sv/pid_pkg.sv */
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, codes and constants of the paletted icon pixel decoder.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int PaletteEntries = 16;
    localparam int ColourW        = 15;

    typedef enum logic [1:0] {
        MODE_PALETTE = 2'd0,
        MODE_BYTE    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic {
        FMT_PAL4 = 1'b0,
        FMT_MONO = 1'b1
    } icon_fmt_t;

    typedef struct packed {
        logic [4:0] pixel_x;
        logic [4:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       mono_ink;
        logic       last_of_item;
    } pixel_t;

    // floor(c * 8.2258) for a 5-bit channel
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd254
    };

endpackage

/* sv/paletted_icon_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// paletted_icon_pixel_decoder
// Turns packed save-icon bytes into a stream of pixels.
//
// Input channel s_*: one word per item. Mode palette writes a BGR555 word
// into the colour table, mode restart clears the pixel position, mode image
// byte yields two palette pixels (4bpp) or eight mono pixels (1bpp), as
// chosen by the icon_format register on cfg_wr_en / cfg_wr_data.
// Output channel m_*: one word per pixel, last_of_item on the final pixel
// of each byte. Palette and restart words yield nothing.
// Each byte is registered in the stepper, and each pixel then passes through
// the result register. Throughput is one pixel per cycle while m_ready does
// not stall, set by the single pixel stepper.
// The next word is taken in the cycle the last pixel of a byte leaves the
// stepper. A stall on m_ready holds the result register and then the
// stepper and the input. Reset clears position, format and valids; the
// colour table is undefined until written.
// ----------------------------------------------------------------------------
module paletted_icon_pixel_decoder #(
    parameter int PALETTE_ENTRIES = pid_pkg::PaletteEntries
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_palette_index,
    input  logic [15:0] s_palette_color,
    input  logic [7:0]  s_image_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_pixel_x,
    output logic [4:0]  m_pixel_y,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_mono_ink,
    output logic        m_last_of_item
);

    logic                         icon_format_reg;
    logic                         accept;
    logic                         out_free;
    logic                         pix_valid;
    logic [3:0]                   lut_index;
    logic [pid_pkg::ColourW-1:0]  lut_rgb;
    pid_pkg::pixel_t              pix;
    pid_pkg::pixel_t              m_pix;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icon_format_reg <= pid_pkg::FMT_PAL4;
        end else if (cfg_wr_en) begin
            icon_format_reg <= cfg_wr_data;
        end
    end

    pid_colour_table #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (accept && (pid_pkg::mode_t'(s_mode) == pid_pkg::MODE_PALETTE)),
        .wr_index (s_palette_index),
        .wr_data  (s_palette_color[pid_pkg::ColourW-1:0]),
        .rd_index (lut_index),
        .rd_data  (lut_rgb)
    );

    pid_pixel_gen u_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .icon_format (icon_format_reg),
        .in_accept   (accept),
        .in_mode     (s_mode),
        .in_byte     (s_image_byte),
        .out_free    (out_free),
        .in_ready    (s_ready),
        .lut_index   (lut_index),
        .lut_rgb     (lut_rgb),
        .pix_valid   (pix_valid),
        .pix         (pix)
    );

    pid_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pix_valid),
        .in_pix   (pix),
        .in_free  (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_pix    (m_pix)
    );

    assign m_pixel_x      = m_pix.pixel_x;
    assign m_pixel_y      = m_pix.pixel_y;
    assign m_red          = m_pix.red;
    assign m_green        = m_pix.green;
    assign m_blue         = m_pix.blue;
    assign m_mono_ink     = m_pix.mono_ink;
    assign m_last_of_item = m_pix.last_of_item;

endmodule

/* sv/pid_colour_table.sv */
// ----------------------------------------------------------------------------
// pid_colour_table
// BGR555 colour table, one write port, one combinational lookup.
// ----------------------------------------------------------------------------
module pid_colour_table #(
    parameter int PALETTE_ENTRIES = pid_pkg::PaletteEntries
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [3:0]                   wr_index,
    input  logic [pid_pkg::ColourW-1:0]  wr_data,
    input  logic [3:0]                   rd_index,
    output logic [pid_pkg::ColourW-1:0]  rd_data
);

    localparam int IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [4:0] Depth = 5'(PALETTE_ENTRIES);

    logic [pid_pkg::ColourW-1:0] entry_reg [PALETTE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en && ({1'b0, wr_index} < Depth)) begin
            entry_reg[wr_index[IdxW-1:0]] <= wr_data;
        end
    end

    always_comb begin
        if ({1'b0, rd_index} < Depth) begin
            rd_data = entry_reg[rd_index[IdxW-1:0]];
        end else begin
            rd_data = '0;
        end
    end

endmodule

/* sv/pid_pixel_gen.sv */
// ----------------------------------------------------------------------------
// pid_pixel_gen
// Holds the current image byte and the pixel position, steps one pixel a cycle while the output register is free.
// ----------------------------------------------------------------------------
module pid_pixel_gen (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         icon_format,
    input  logic                         in_accept,
    input  logic [1:0]                   in_mode,
    input  logic [7:0]                   in_byte,
    input  logic                         out_free,
    output logic                         in_ready,
    output logic [3:0]                   lut_index,
    input  logic [pid_pkg::ColourW-1:0]  lut_rgb,
    output logic                         pix_valid,
    output pid_pkg::pixel_t              pix
);

    logic        busy_reg, busy_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  pos_adv;
    logic        last;
    logic        emit;
    pid_pkg::mode_t mode;

    assign mode      = pid_pkg::mode_t'(in_mode);
    assign emit      = busy_reg && out_free;
    assign pix_valid = emit;
    assign in_ready  = !busy_reg || (emit && last);
    assign lut_index = cnt_reg[0] ? byte_reg[7:4] : byte_reg[3:0];

    always_comb begin
        pix = '0;
        if (icon_format == pid_pkg::FMT_MONO) begin
            last             = (cnt_reg == 3'd7);
            pix.pixel_x      = pos_reg[4:0];
            pix.pixel_y      = pos_reg[9:5];
            pix.mono_ink     = ~byte_reg[cnt_reg];
            pos_adv          = pos_reg + 10'd1;
        end else begin
            last             = (cnt_reg == 3'd1);
            pix.pixel_x      = {1'b0, pos_reg[3:0]};
            pix.pixel_y      = {1'b0, pos_reg[7:4]};
            pix.red          = pid_pkg::EXPAND5[lut_rgb[4:0]];
            pix.green        = pid_pkg::EXPAND5[lut_rgb[9:5]];
            pix.blue         = pid_pkg::EXPAND5[lut_rgb[14:10]];
            pos_adv          = {2'b00, pos_reg[7:0] + 8'd1};
        end
        pix.last_of_item = last;
    end

    always_comb begin
        busy_next = busy_reg;
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        if (emit) begin
            pos_next = pos_adv;
            cnt_next = cnt_reg + 3'd1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (in_accept) begin
            case (mode)
                pid_pkg::MODE_BYTE: begin
                    busy_next = 1'b1;
                    byte_next = in_byte;
                    cnt_next  = '0;
                end
                pid_pkg::MODE_RESTART: begin
                    pos_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

/* sv/pid_out_reg.sv */
// ----------------------------------------------------------------------------
// pid_out_reg
// Result register towards the pixel channel.
// ----------------------------------------------------------------------------
module pid_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  pid_pkg::pixel_t in_pix,
    output logic            in_free,
    output logic            m_valid,
    input  logic            m_ready,
    output pid_pkg::pixel_t m_pix
);

    logic            valid_reg;
    pid_pkg::pixel_t pix_reg;

    assign in_free = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_pix   = pix_reg;

    always_ff @(posedge aclk) begin
        if (in_valid && in_free) begin
            pix_reg <= in_pix;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_free) begin
            valid_reg <= in_valid;
        end
    end

endmodule

/* bench/tb_paletted_icon_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// tb_paletted_icon_pixel_decoder
// Self-checking bench for the paletted icon pixel decoder. Palette, restart
// and image words are pushed through the s_ channel with random gaps, and
// m_ready is stalled at random. A shadow colour table and pixel position
// predict every pixel word, which is checked field by field in order. The
// run covers both icon formats, every palette entry, wrap of the 4bpp
// position and a format change part way through an image.
// ----------------------------------------------------------------------------
module tb_paletted_icon_pixel_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HalfPeriod = 5;
    localparam int CycleLimit = 500_000;

    class icon_pixel_predictor;
        logic [14:0]        clut [pid_pkg::PaletteEntries];
        logic [9:0]         position;
        pid_pkg::icon_fmt_t fmt;
        pid_pkg::pixel_t    pixels_due [$];
        int                 errors;

        function new();
            foreach (clut[i]) clut[i] = '0;
            position = '0;
            fmt      = pid_pkg::FMT_PAL4;
            errors   = 0;
        endfunction

        function logic [7:0] widen5(logic [4:0] c);
            return 8'((int'(c) * 82258) / 10000);
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        // Works out the pixels caused by one accepted word
        function void decode_word(pid_pkg::mode_t m, logic [3:0] idx,
                                  logic [15:0] col, logic [7:0] b);
            pid_pkg::pixel_t p;
            logic [7:0]      pos8;
            logic [3:0]      nib;
            logic [14:0]     rgb;
            case (m)
                pid_pkg::MODE_PALETTE: begin
                    if (int'(idx) < pid_pkg::PaletteEntries) clut[idx] = col[14:0];
                end
                pid_pkg::MODE_RESTART: begin
                    position = '0;
                end
                pid_pkg::MODE_BYTE: begin
                    if (fmt == pid_pkg::FMT_PAL4) begin
                        for (int k = 0; k < 2; k++) begin
                            pos8 = position[7:0];
                            nib  = (k == 0) ? b[3:0] : b[7:4];
                            rgb  = (int'(nib) < pid_pkg::PaletteEntries) ?
                                   clut[nib] : '0;
                            p.pixel_x      = {1'b0, pos8[3:0]};
                            p.pixel_y      = {1'b0, pos8[7:4]};
                            p.red          = widen5(rgb[4:0]);
                            p.green        = widen5(rgb[9:5]);
                            p.blue         = widen5(rgb[14:10]);
                            p.mono_ink     = 1'b0;
                            p.last_of_item = (k == 1);
                            pixels_due.push_back(p);
                            position = {2'b00, pos8 + 8'd1};
                        end
                    end else begin
                        for (int k = 0; k < 8; k++) begin
                            p.pixel_x      = position[4:0];
                            p.pixel_y      = position[9:5];
                            p.red          = '0;
                            p.green        = '0;
                            p.blue         = '0;
                            p.mono_ink     = ~b[k];
                            p.last_of_item = (k == 7);
                            pixels_due.push_back(p);
                            position = position + 10'd1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pid_pkg::pixel_t got);
            pid_pkg::pixel_t want;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel word x=%0d y=%0d, expected none, got %h",
                         $time, got.pixel_x, got.pixel_y, got);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            compare("pixel_x", 8'(want.pixel_x), 8'(got.pixel_x));
            compare("pixel_y", 8'(want.pixel_y), 8'(got.pixel_y));
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("mono_ink", 8'(want.mono_ink), 8'(got.mono_ink));
            compare("last_of_item", 8'(want.last_of_item), 8'(got.last_of_item));
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           cfg_wr_en;
    logic           cfg_wr_data;
    logic           s_valid;
    logic           s_ready;
    pid_pkg::mode_t s_mode;
    logic [3:0]     s_palette_index;
    logic [15:0]    s_palette_color;
    logic [7:0]     s_image_byte;
    logic           m_valid;
    logic           m_ready;
    logic [4:0]     m_pixel_x;
    logic [4:0]     m_pixel_y;
    logic [7:0]     m_red;
    logic [7:0]     m_green;
    logic [7:0]     m_blue;
    logic           m_mono_ink;
    logic           m_last_of_item;

    icon_pixel_predictor decoder = new();
    bit                  steady  = 1'b0;
    int                  cycle_count = 0;

    paletted_icon_pixel_decoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_image_byte    (s_image_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_mono_ink      (m_mono_ink),
        .m_last_of_item  (m_last_of_item)
    );

    always #HalfPeriod aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones; none while steady is set
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // valid is left high after acceptance so back-to-back words need no drop
    task automatic send_word(pid_pkg::mode_t m, logic [3:0] idx, logic [15:0] col,
                             logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= m;
        s_palette_index <= idx;
        s_palette_color <= col;
        s_image_byte    <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        decoder.decode_word(m, idx, col, b);
    endtask

    task automatic set_format(pid_pkg::icon_fmt_t f);
        s_valid <= 1'b0;
        while (decoder.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        decoder.fmt = f;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(pid_pkg::MODE_BYTE, 4'($urandom), 16'($urandom), b);
    endtask

    task automatic run_phase(int n_bytes, int restart_pct, int noise_pct);
        int         bytes_sent;
        int         r;
        logic [7:0] b;
        bytes_sent = 0;
        while (bytes_sent < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < restart_pct) begin
                send_word(pid_pkg::MODE_RESTART, 4'($urandom), 16'($urandom),
                          8'($urandom));
            end else if (r < restart_pct + noise_pct) begin
                if (r[0]) begin
                    send_word(pid_pkg::MODE_PALETTE, 4'($urandom), 16'($urandom),
                              8'($urandom));
                end else begin
                    send_word(pid_pkg::MODE_NONE, 4'($urandom), 16'($urandom),
                              8'($urandom));
                end
            end else begin
                b = 8'($urandom);
                if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                send_byte(b);
                bytes_sent++;
            end
        end
    endtask

    initial begin
        pid_pkg::pixel_t got;
        int              hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.pixel_x      = m_pixel_x;
                got.pixel_y      = m_pixel_y;
                got.red          = m_red;
                got.green        = m_green;
                got.blue         = m_blue;
                got.mono_ink     = m_mono_ink;
                got.last_of_item = m_last_of_item;
                decoder.check_pixel(got);
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin
        logic [15:0] col;
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 1'b0;
        s_valid         <= 1'b0;
        s_mode          <= pid_pkg::MODE_NONE;
        s_palette_index <= '0;
        s_palette_color <= '0;
        s_image_byte    <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the whole table first so that no lookup hits an unwritten entry
        set_format(pid_pkg::FMT_PAL4);
        for (int i = 0; i < pid_pkg::PaletteEntries; i++) begin
            case (i)
                0:       col = 16'h0000;
                1:       col = 16'h001F;
                2:       col = 16'h03E0;
                3:       col = 16'h7C00;
                4:       col = 16'h8000;
                5:       col = 16'h7FFF;
                15:      col = 16'hFFFF;
                default: col = 16'($urandom);
            endcase
            send_word(pid_pkg::MODE_PALETTE, 4'(i), col, 8'($urandom));
        end
        send_byte(8'hF0);
        send_byte(8'h0F);
        send_word(pid_pkg::MODE_NONE, 4'hF, 16'hFFFF, 8'hFF);
        send_word(pid_pkg::MODE_RESTART, 4'hF, 16'hFFFF, 8'hFF);
        send_byte(8'h54);

        set_format(pid_pkg::FMT_MONO);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);

        // 240 mono pixels, then 4bpp carries on from the masked position
        // and wraps past the end of the image
        send_word(pid_pkg::MODE_RESTART, 4'h0, 16'h0000, 8'h00);
        run_phase(30, 0, 0);
        set_format(pid_pkg::FMT_PAL4);
        run_phase(20, 0, 10);

        steady = 1'b1;
        set_format(pid_pkg::FMT_MONO);
        run_phase(12, 10, 15);
        steady = 1'b0;
        set_format(pid_pkg::FMT_PAL4);
        run_phase(12, 10, 15);

        s_valid <= 1'b0;
        while (decoder.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (decoder.errors == 0 && decoder.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
